// ===== rtl/skf_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// skf_pkg - shared types and constants
// Field widths, fixed-point constants, sequencer states and request formats
// for the multichannel scalar Kalman filter.
// ----------------------------------------------------------------------------
package skf_pkg;

    localparam int CHANNELS_DEF = 7;

    localparam int CHAN_W   = 3;
    localparam int SAMPLE_W = 16;
    localparam int EST_W    = 32;
    localparam int GAIN_W   = 31;
    localparam int NOISE_W  = 31;
    localparam int COV_W    = 32;
    localparam int PP_W     = 34;   // p + q
    localparam int DEN_W    = 35;   // p + q + r
    localparam int DIFF_W   = 33;   // z - x
    localparam int MUL_A_W  = 32;
    localparam int MUL_B_W  = 18;
    localparam int PROD_W   = MUL_A_W + MUL_B_W;
    localparam int ACC_W    = 66;
    localparam int SPLIT    = 17;   // low slice width of the split operand
    localparam int FRAC     = 30;
    localparam int SUM_W    = ACC_W - FRAC + 1;

    localparam int DIV_STEPS = GAIN_W;

    localparam logic [GAIN_W-1:0]         ONE_Q30  = GAIN_W'(1) << FRAC;
    localparam logic signed [ACC_W-1:0]   HALF_Q30 = ACC_W'(1) << (FRAC - 1);
    localparam logic [NOISE_W-1:0]        Q_RESET  = NOISE_W'(10737);
    localparam logic [NOISE_W-1:0]        R_RESET  = NOISE_W'(21474836);
    localparam logic signed [EST_W-1:0]   EST_MAX  = {1'b0, {(EST_W-1){1'b1}}};
    localparam logic signed [EST_W-1:0]   EST_MIN  = {1'b1, {(EST_W-1){1'b0}}};

    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] REG_PROCESS_NOISE     = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_MEASUREMENT_NOISE = 1'b1;

    typedef struct packed {
        logic [CHAN_W-1:0]          channel;
        logic signed [SAMPLE_W-1:0] sample;
    } item_t;

    typedef struct packed {
        logic [CHAN_W-1:0]          channel_out;
        logic signed [EST_W-1:0]    estimate_out;
        logic [GAIN_W-1:0]          gain_out;
    } result_t;

    typedef struct packed {
        logic mul;      // capture a product
        logic hi;       // product belongs to the upper slice
        logic acc;      // add the held product
        logic clr;      // preset accumulator to the rounding half
    } mac_ctrl_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_READ,
        S_DEN,
        S_DIV,
        S_MUL_DL,
        S_MUL_DH,
        S_ACC_D,
        S_EST,
        S_MUL_PL,
        S_MUL_PH,
        S_ACC_P,
        S_WRITE,
        S_RESULT
    } state_t;

endpackage

// ===== rtl/skf_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// skf_ram - generic single-port-write RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module skf_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = skf_pkg::CHANNELS_DEF,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/skf_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// skf_div - restoring fractional divider
// Gives floor(num * 2^30 / den) for num <= den, one quotient bit per cycle.
// A zero divisor gives a zero quotient.
// ----------------------------------------------------------------------------
module skf_div (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  logic [skf_pkg::PP_W-1:0]       num,
    input  logic [skf_pkg::DEN_W-1:0]      den,
    output logic                           done,
    output logic [skf_pkg::GAIN_W-1:0]     quo
);

    localparam int CNT_W = $clog2(skf_pkg::DIV_STEPS);
    localparam int REM_W = skf_pkg::DEN_W + 1;

    logic                        run_reg, run_next;
    logic                        done_reg, done_next;
    logic [CNT_W-1:0]            cnt_reg, cnt_next;
    logic [REM_W-1:0]            rem_reg;
    logic [skf_pkg::DEN_W-1:0]   den_reg;
    logic [skf_pkg::GAIN_W-1:0]  quo_reg;
    logic                        zero_reg;

    logic                        ge;
    logic [REM_W-1:0]            diff;
    logic                        last;

    assign ge   = rem_reg >= {1'b0, den_reg};
    assign diff = ge ? (rem_reg - {1'b0, den_reg}) : rem_reg;
    assign last = cnt_reg == CNT_W'(skf_pkg::DIV_STEPS - 1);

    always_comb
    begin
        run_next  = run_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        if (start)
        begin
            run_next = 1'b1;
            cnt_next = '0;
        end
        else if (run_reg)
        begin
            cnt_next = cnt_reg + CNT_W'(1);
            if (last)
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg  <= REM_W'(num);
            den_reg  <= den;
            quo_reg  <= '0;
            zero_reg <= (den == '0);
        end
        else if (run_reg)
        begin
            rem_reg <= {diff[REM_W-2:0], 1'b0};
            quo_reg <= {quo_reg[skf_pkg::GAIN_W-2:0], ge};
        end
    end

    assign done = done_reg;
    assign quo  = zero_reg ? '0 : quo_reg;

endmodule

// ===== rtl/skf_mac.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// skf_mac - shared multiply-accumulate unit
// Registered 32x18 signed product, then a 66-bit accumulate with an optional
// shift of the product by the low slice width.
// ----------------------------------------------------------------------------
module skf_mac (
    input  logic                                 clk,
    input  skf_pkg::mac_ctrl_t                   ctrl,
    input  logic signed [skf_pkg::MUL_A_W-1:0]   a,
    input  logic signed [skf_pkg::MUL_B_W-1:0]   b,
    output logic signed [skf_pkg::ACC_W-1:0]     acc
);

    logic signed [skf_pkg::PROD_W-1:0] prod_reg;
    logic                              hi_reg;
    logic signed [skf_pkg::ACC_W-1:0]  acc_reg;
    logic signed [skf_pkg::ACC_W-1:0]  prod_x;
    logic signed [skf_pkg::ACC_W-1:0]  addend;

    assign prod_x = skf_pkg::ACC_W'(prod_reg);
    assign addend = hi_reg ? (prod_x <<< skf_pkg::SPLIT) : prod_x;

    always_ff @(posedge clk)
    begin
        if (ctrl.mul)
        begin
            prod_reg <= a * b;
            hi_reg   <= ctrl.hi;
        end
        if (ctrl.clr)
        begin
            acc_reg <= skf_pkg::HALF_Q30;
        end
        else if (ctrl.acc)
        begin
            acc_reg <= acc_reg + addend;
        end
    end

    assign acc = acc_reg;

endmodule

// ===== rtl/scalar_kalman_multichannel_top.sv =====
`timescale 1ns / 1ps
// A new request stalls until the last one leaves the result state; a channel
// beyond the store skips the update. The pace is set by the 31-step serial
// divider that forms the gain, plus the shared multiplier passes.
// Reset: estimates clear to zero and covariances to 1.0 through per-channel
// valid bits at once; noise registers return to their defaults.
// ----------------------------------------------------------------------------
// scalar_kalman_multichannel_top - multichannel scalar Kalman filter
// Per-channel estimate and covariance update with a shared divider and a
// shared multiply-accumulate unit under a small sequencer.
// ----------------------------------------------------------------------------
module scalar_kalman_multichannel_top #(
    parameter int CHANNELS = skf_pkg::CHANNELS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              item_valid,
    output logic                              item_stall,
    input  skf_pkg::item_t                    item,
    output logic                              result_valid,
    input  logic                              result_stall,
    output skf_pkg::result_t                  result,
    input  logic                              cfg_write,
    input  logic [skf_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [skf_pkg::NOISE_W-1:0]       cfg_data
);

    localparam int AW    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int XW    = (AW > skf_pkg::CHAN_W) ? AW : skf_pkg::CHAN_W;
    localparam int RAM_W = skf_pkg::EST_W + skf_pkg::COV_W;
    localparam int EW    = skf_pkg::EST_W;
    localparam int CW    = skf_pkg::COV_W;
    localparam int DW    = skf_pkg::DIFF_W;
    localparam int PW    = skf_pkg::PP_W;
    localparam int SP    = skf_pkg::SPLIT;
    localparam int FR    = skf_pkg::FRAC;
    localparam int AC    = skf_pkg::ACC_W;
    localparam int SW    = skf_pkg::SUM_W;

    skf_pkg::state_t state_reg, state_next;

    logic [skf_pkg::NOISE_W-1:0]      q_reg, r_reg;
    logic [CHANNELS-1:0]              valid_reg;

    logic [skf_pkg::CHAN_W-1:0]       chan_reg;
    logic signed [skf_pkg::SAMPLE_W-1:0] samp_reg;
    logic [AW-1:0]                    addr_reg;
    logic                             oor_reg;
    logic signed [EW-1:0]             x_reg;
    logic [PW-1:0]                    pp_reg;
    logic signed [DW-1:0]             d_reg;
    logic [skf_pkg::GAIN_W-1:0]       k_reg;
    logic signed [EW-1:0]             est_reg;

    logic                             result_valid_reg;
    skf_pkg::result_t                 result_reg;

    logic                             accept;
    logic                             out_free;
    logic                             in_oor;
    logic [XW-1:0]                    chan_x;
    logic [AW-1:0]                    in_addr;

    logic [RAM_W-1:0]                 rdata;
    logic                             ram_we;
    logic [RAM_W-1:0]                 wdata;
    logic                             hit;
    logic [CW-1:0]                    p_rd;
    logic signed [EW-1:0]             x_rd;
    logic signed [EW-1:0]             z;
    logic [skf_pkg::DEN_W-1:0]        den;

    logic                             div_start;
    logic                             div_done;
    logic [skf_pkg::GAIN_W-1:0]       div_quo;

    skf_pkg::mac_ctrl_t               mac_ctrl;
    logic signed [skf_pkg::MUL_A_W-1:0] mac_a;
    logic signed [skf_pkg::MUL_B_W-1:0] mac_b;
    logic signed [AC-1:0]             acc;
    logic [skf_pkg::GAIN_W-1:0]       omk;

    logic signed [SW-1:0]             est_sum;
    logic signed [EW-1:0]             est_sat;
    logic [CW-1:0]                    p_new;

    // ---- request side
    assign item_stall = (state_reg != skf_pkg::S_IDLE);
    assign accept     = item_valid && !item_stall;
    assign chan_x     = XW'(item.channel);
    assign in_addr    = chan_x[AW-1:0];
    assign in_oor     = 32'(item.channel) >= CHANNELS;
    assign out_free   = !result_valid_reg || !result_stall;

    // ---- configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            q_reg <= skf_pkg::Q_RESET;
            r_reg <= skf_pkg::R_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                skf_pkg::REG_PROCESS_NOISE:     q_reg <= cfg_data;
                skf_pkg::REG_MEASUREMENT_NOISE: r_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // ---- sequencer: next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            skf_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    state_next = in_oor ? skf_pkg::S_RESULT : skf_pkg::S_READ;
                end
            end
            skf_pkg::S_READ:   state_next = skf_pkg::S_DEN;
            skf_pkg::S_DEN:    state_next = skf_pkg::S_DIV;
            skf_pkg::S_DIV:
            begin
                if (div_done)
                begin
                    state_next = skf_pkg::S_MUL_DL;
                end
            end
            skf_pkg::S_MUL_DL: state_next = skf_pkg::S_MUL_DH;
            skf_pkg::S_MUL_DH: state_next = skf_pkg::S_ACC_D;
            skf_pkg::S_ACC_D:  state_next = skf_pkg::S_EST;
            skf_pkg::S_EST:    state_next = skf_pkg::S_MUL_PL;
            skf_pkg::S_MUL_PL: state_next = skf_pkg::S_MUL_PH;
            skf_pkg::S_MUL_PH: state_next = skf_pkg::S_ACC_P;
            skf_pkg::S_ACC_P:  state_next = skf_pkg::S_WRITE;
            skf_pkg::S_WRITE:  state_next = skf_pkg::S_RESULT;
            skf_pkg::S_RESULT:
            begin
                if (out_free)
                begin
                    state_next = skf_pkg::S_IDLE;
                end
            end
            default:           state_next = skf_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= skf_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // ---- sequencer: outputs
    assign omk = skf_pkg::ONE_Q30 - k_reg;

    always_comb
    begin
        mac_ctrl  = '0;
        mac_a     = '0;
        mac_b     = '0;
        div_start = 1'b0;
        ram_we    = 1'b0;
        case (state_reg)
            skf_pkg::S_DEN:
            begin
                div_start = 1'b1;
            end
            skf_pkg::S_MUL_DL:
            begin
                mac_ctrl.mul = 1'b1;
                mac_ctrl.clr = 1'b1;
                mac_a        = {1'b0, k_reg};
                mac_b        = {1'b0, d_reg[SP-1:0]};
            end
            skf_pkg::S_MUL_DH:
            begin
                mac_ctrl.mul = 1'b1;
                mac_ctrl.hi  = 1'b1;
                mac_ctrl.acc = 1'b1;
                mac_a        = {1'b0, k_reg};
                mac_b        = skf_pkg::MUL_B_W'($signed(d_reg[DW-1:SP]));
            end
            skf_pkg::S_MUL_PL:
            begin
                mac_ctrl.mul = 1'b1;
                mac_ctrl.clr = 1'b1;
                mac_a        = {1'b0, omk};
                mac_b        = {1'b0, pp_reg[SP-1:0]};
            end
            skf_pkg::S_MUL_PH:
            begin
                mac_ctrl.mul = 1'b1;
                mac_ctrl.hi  = 1'b1;
                mac_ctrl.acc = 1'b1;
                mac_a        = {1'b0, omk};
                mac_b        = {1'b0, pp_reg[PW-1:SP]};
            end
            skf_pkg::S_ACC_D, skf_pkg::S_ACC_P:
            begin
                mac_ctrl.acc = 1'b1;
            end
            skf_pkg::S_WRITE:
            begin
                ram_we = 1'b1;
            end
            default: ;
        endcase
    end

    // ---- channel store
    skf_ram #(
        .WIDTH (RAM_W),
        .DEPTH (CHANNELS),
        .AW    (AW)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (addr_reg),
        .wdata (wdata),
        .raddr (in_addr),
        .rdata (rdata)
    );

    assign hit  = valid_reg[addr_reg];
    assign p_rd = hit ? rdata[CW-1:0] : CW'(skf_pkg::ONE_Q30);
    assign x_rd = hit ? $signed(rdata[RAM_W-1:CW]) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (ram_we)
        begin
            valid_reg[addr_reg] <= 1'b1;
        end
    end

    // ---- shared units
    assign den = skf_pkg::DEN_W'(pp_reg) + skf_pkg::DEN_W'(r_reg);

    skf_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (pp_reg),
        .den   (den),
        .done  (div_done),
        .quo   (div_quo)
    );

    skf_mac u_mac (
        .clk  (clk),
        .ctrl (mac_ctrl),
        .a    (mac_a),
        .b    (mac_b),
        .acc  (acc)
    );

    // ---- datapath
    assign z       = {samp_reg, 16'h0000};
    assign est_sum = SW'(x_reg) + SW'($signed(acc[AC-1:FR]));
    assign est_sat = (est_sum > SW'(skf_pkg::EST_MAX)) ? skf_pkg::EST_MAX :
                     (est_sum < SW'(skf_pkg::EST_MIN)) ? skf_pkg::EST_MIN :
                     est_sum[EW-1:0];
    assign p_new   = (|acc[AC-1:FR+CW]) ? {CW{1'b1}} : acc[FR+CW-1:FR];
    assign wdata   = {est_reg, p_new};

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            chan_reg <= item.channel;
            samp_reg <= item.sample;
            addr_reg <= in_addr;
            oor_reg  <= in_oor;
        end
        if (state_reg == skf_pkg::S_READ)
        begin
            x_reg  <= x_rd;
            pp_reg <= PW'(p_rd) + PW'(q_reg);
        end
        if (state_reg == skf_pkg::S_DEN)
        begin
            d_reg <= DW'(z) - DW'(x_reg);
        end
        if (div_done)
        begin
            k_reg <= div_quo;
        end
        if (state_reg == skf_pkg::S_EST)
        begin
            est_reg <= est_sat;
        end
    end

    // ---- result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (state_reg == skf_pkg::S_RESULT && out_free)
        begin
            result_valid_reg <= 1'b1;
        end
        else if (!result_stall)
        begin
            result_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == skf_pkg::S_RESULT && out_free)
        begin
            result_reg.channel_out  <= chan_reg;
            result_reg.estimate_out <= oor_reg ? '0 : est_reg;
            result_reg.gain_out     <= oor_reg ? '0 : k_reg;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

`ifndef ASSERT_OFF
    a_gain_bound: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (result.gain_out <= skf_pkg::ONE_Q30))
        else $error("gain above one");

    a_oor_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && (32'(result.channel_out) >= CHANNELS))
        |-> (result.estimate_out == '0 && result.gain_out == '0))
        else $error("unused channel returned non-zero result");

    a_div_done: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == skf_pkg::S_DIV))
        else $error("divider finished outside its wait state");

    a_store_write: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> (!oor_reg && ($past(state_reg) == skf_pkg::S_ACC_P)))
        else $error("store written out of sequence");
`endif

endmodule
